FILE: rtl/rcim_pkg.sv
`timescale 1ns / 1ps
package rcim_pkg;

   localparam int MAX_ROWS   = 256;
   localparam int MAX_COLS   = 256;
   localparam int COUNT_BITS = 16;

   localparam int CELLS  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   localparam int COORD_W    = 9;
   localparam int CFG_W      = 9;
   localparam int ACTION_W   = 2;
   localparam int STATUS_W   = 2;
   localparam int CNT_OUT_W  = 16;

   typedef logic [COORD_W-1:0]    coord_type;
   typedef logic [CFG_W-1:0]      cfg_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   localparam count_type COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

   localparam logic REG_NUM_ROWS = 1'b0;
   localparam logic REG_NUM_COLS = 1'b1;

   localparam cfg_type CFG_RESET = 9'd256;

   // 1-based coordinate inside both the programmed size and the physical size
   function automatic logic coord_ok(input coord_type v, input cfg_type size, input int limit);
      logic ok;
      ok = (v != '0) && (v <= size) && (32'(v) <= limit);
      return ok;
   endfunction

endpackage

FILE: rtl/rectangle_increment_count_matrix_core.sv
`timescale 1ns / 1ps
// add: one cell read-modify-write per cycle, then a drain state and the registered result strobe;
//   an empty or rejected rectangle and a bad action code answer in the cycle after the transfer
// read: a single-cell walk, then the drain state registers the result; clear: one memory entry per cycle,
//   result strobe at the end of the pass; next transfer at the edge ending the strobe
// reset: synchronous; a clearing pass over all MAX_ROWS*MAX_COLS entries runs with busy high
// results cannot be stalled: each strobe lasts exactly one cycle
module rectangle_increment_count_matrix_core
   import rcim_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [COORD_W-1:0]   req_row_first,
   input  logic [COORD_W-1:0]   req_row_last,
   input  logic [COORD_W-1:0]   req_col_first,
   input  logic [COORD_W-1:0]   req_col_last,
   output logic                 rsp_valid,
   output logic [CNT_OUT_W-1:0] rsp_cell_count,
   output logic [STATUS_W-1:0]  rsp_status,
   input  logic                 csr_wr_en,
   input  logic                 csr_index,
   input  logic [CFG_W-1:0]     csr_wr_data
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;
   localparam logic [1:0] S_DRAIN = 2'd3;

   logic [1:0] state_ff, state_in;
   cfg_type    num_rows_ff, num_cols_ff;
   addr_type   clr_addr_ff, clr_addr_in;
   logic       clr_rsp_ff, clr_rsp_in;
   logic       wr_pend_ff;
   addr_type   wr_addr_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [CNT_OUT_W-1:0] rsp_cell_count_ff, rsp_cell_count_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   coord_type  row_cur_ff, row_cur_in;
   coord_type  row_last_ff, row_last_in;
   coord_type  col_cur_ff, col_cur_in;
   coord_type  col_first_ff, col_first_in;
   coord_type  col_last_ff, col_last_in;
   addr_type   row_base_ff, row_base_in;
   logic       read_mode_ff, read_mode_in;
   logic       sat_ff, sat_in;

   count_type  count_mem [CELLS];
   count_type  rd_data_ff;

   logic       rd_en;
   addr_type   rd_addr;
   logic       sat_now;
   count_type  inc_data;
   logic       mem_we;
   addr_type   mem_waddr;
   count_type  mem_wdata;
   logic       add_ok, add_empty, read_ok;

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_count = rsp_cell_count_ff;
   assign rsp_status     = rsp_status_ff;

   assign rd_en    = (state_ff == S_WALK);
   assign rd_addr  = row_base_ff + ADDR_W'(col_cur_ff - COORD_W'(1));
   assign sat_now  = (rd_data_ff == COUNT_MAX);
   assign inc_data = sat_now ? rd_data_ff : rd_data_ff + COUNT_BITS'(1);

   // the clearing pass and the write-back stage share the write port
   assign mem_we    = (state_ff == S_CLEAR) || (wr_pend_ff && !read_mode_ff);
   assign mem_waddr = (state_ff == S_CLEAR) ? clr_addr_ff : wr_addr_ff;
   assign mem_wdata = (state_ff == S_CLEAR) ? '0 : inc_data;

   assign add_ok = coord_ok(req_row_first, num_rows_ff, MAX_ROWS)
                && coord_ok(req_row_last, num_rows_ff, MAX_ROWS)
                && coord_ok(req_col_first, num_cols_ff, MAX_COLS)
                && coord_ok(req_col_last, num_cols_ff, MAX_COLS);
   assign add_empty = (req_row_first > req_row_last) || (req_col_first > req_col_last);
   assign read_ok = coord_ok(req_row_first, num_rows_ff, MAX_ROWS)
                 && coord_ok(req_col_first, num_cols_ff, MAX_COLS);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= count_mem[rd_addr];
      end
   end

   always_comb begin
      state_in          = state_ff;
      clr_addr_in       = clr_addr_ff;
      clr_rsp_in        = clr_rsp_ff;
      rsp_valid_in      = 1'b0;
      rsp_cell_count_in = '0;
      rsp_status_in     = ST_OK;
      row_cur_in        = row_cur_ff;
      row_last_in       = row_last_ff;
      col_cur_in        = col_cur_ff;
      col_first_in      = col_first_ff;
      col_last_in       = col_last_ff;
      row_base_in       = row_base_ff;
      read_mode_in      = read_mode_ff;
      sat_in            = sat_ff | (wr_pend_ff && !read_mode_ff && sat_now);

      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(CELLS - 1)) begin
               state_in     = S_IDLE;
               clr_addr_in  = '0;
               clr_rsp_in   = 1'b0;
               rsp_valid_in = clr_rsp_ff;
            end
         end
         S_IDLE: begin
            if (start) begin
               row_cur_in   = req_row_first;
               row_base_in  = ADDR_W'(32'(req_row_first - COORD_W'(1)) * MAX_COLS);
               col_cur_in   = req_col_first;
               col_first_in = req_col_first;
               sat_in       = 1'b0;
               unique case (req_action)
                  ACT_ADD: begin
                     row_last_in  = req_row_last;
                     col_last_in  = req_col_last;
                     read_mode_in = 1'b0;
                     if (!add_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else if (add_empty) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  ACT_READ: begin
                     // a single-cell walk with the write-back suppressed
                     row_last_in  = req_row_first;
                     col_last_in  = req_col_first;
                     read_mode_in = 1'b1;
                     if (!read_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  ACT_CLEAR: begin
                     state_in    = S_CLEAR;
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (col_cur_ff == col_last_ff) begin
               if (row_cur_ff == row_last_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  row_cur_in  = row_cur_ff + COORD_W'(1);
                  row_base_in = row_base_ff + ADDR_W'(MAX_COLS);
                  col_cur_in  = col_first_ff;
               end
            end else begin
               col_cur_in = col_cur_ff + COORD_W'(1);
            end
         end
         S_DRAIN: begin
            // last write-back lands at this edge
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (read_mode_ff) begin
               rsp_cell_count_in = CNT_OUT_W'(rd_data_ff);
            end else if (sat_ff || sat_now) begin
               rsp_status_in = ST_SAT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         num_rows_ff  <= CFG_RESET;
         num_cols_ff  <= CFG_RESET;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         wr_pend_ff   <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            if (csr_index == REG_NUM_ROWS) begin
               num_rows_ff <= csr_wr_data;
            end
            if (csr_index == REG_NUM_COLS) begin
               num_cols_ff <= csr_wr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff        <= rd_addr;
      rsp_cell_count_ff <= rsp_cell_count_in;
      rsp_status_ff     <= rsp_status_in;
      row_cur_ff        <= row_cur_in;
      row_last_ff       <= row_last_in;
      col_cur_ff        <= col_cur_in;
      col_first_ff      <= col_first_in;
      col_last_ff       <= col_last_in;
      row_base_ff       <= row_base_in;
      read_mode_ff      <= read_mode_in;
      sat_ff            <= sat_in;
   end

endmodule

FILE: tb/sv/rectangle_increment_count_matrix_core_tb.sv
`timescale 1ns / 1ps
module rectangle_increment_count_matrix_core_tb
   import rcim_pkg::*;
();

   localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;
   localparam int                  RUN_LIMIT_NS = 12_000_000;
   localparam int                  MAX_REPORTS  = 100;

   typedef struct packed {
      logic [CNT_OUT_W-1:0] count;
      logic [STATUS_W-1:0]  status;
   } reply_type;

   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 start          = 1'b0;
   logic                 busy;
   logic [ACTION_W-1:0]  req_action     = ACT_ADD;
   coord_type            req_row_first  = '0;
   coord_type            req_row_last   = '0;
   coord_type            req_col_first  = '0;
   coord_type            req_col_last   = '0;
   logic                 rsp_valid;
   logic [CNT_OUT_W-1:0] rsp_cell_count;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 csr_wr_en      = 1'b0;
   logic                 csr_index      = REG_NUM_ROWS;
   cfg_type              csr_wr_data    = '0;

   // shadow of the count matrix and the size registers
   count_type   cell_counts [CELLS];
   cfg_type     rows_cfg = CFG_RESET;
   cfg_type     cols_cfg = CFG_RESET;

   reply_type   expected_replies [$];
   reply_type   oldest_reply;
   int unsigned mismatches = 0;
   int          sender_idle_pct = 0;
   coord_type   hot_row = 9'd1;
   coord_type   hot_col = 9'd1;

   rectangle_increment_count_matrix_core u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_row_first  (req_row_first),
      .req_row_last   (req_row_last),
      .req_col_first  (req_col_first),
      .req_col_last   (req_col_last),
      .rsp_valid      (rsp_valid),
      .rsp_cell_count (rsp_cell_count),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int rows_in_use();
      return (int'(rows_cfg) > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
   endfunction

   function automatic int cols_in_use();
      return (int'(cols_cfg) > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
   endfunction

   function automatic bit in_range(input coord_type v, input int size);
      return (int'(v) >= 1) && (int'(v) <= size);
   endfunction

   function automatic void clear_counts();
      foreach (cell_counts[i]) cell_counts[i] = '0;
   endfunction

   // applies one item to the shadow matrix and returns the reply it should give
   function automatic reply_type predict_reply(input logic [ACTION_W-1:0] act,
                                               input coord_type r0, input coord_type r1,
                                               input coord_type c0, input coord_type c1);
      reply_type rep;
      int        nr, nc, r, c, k;
      rep.count  = '0;
      rep.status = ST_OK;
      nr = rows_in_use();
      nc = cols_in_use();
      case (act)
         ACT_ADD: begin
            // all four corners are checked, even for an empty range
            if (!in_range(r0, nr) || !in_range(r1, nr) ||
                !in_range(c0, nc) || !in_range(c1, nc)) begin
               rep.status = ST_RANGE;
            end else begin
               for (r = r0; r <= int'(r1); r++) begin
                  for (c = c0; c <= int'(c1); c++) begin
                     k = (r - 1) * MAX_COLS + (c - 1);
                     if (cell_counts[k] == COUNT_MAX) begin
                        rep.status = ST_SAT;
                     end else begin
                        cell_counts[k] = cell_counts[k] + 1'b1;
                     end
                  end
               end
            end
         end
         ACT_READ: begin
            if (!in_range(r0, nr) || !in_range(c0, nc)) begin
               rep.status = ST_RANGE;
            end else begin
               rep.count = CNT_OUT_W'(cell_counts[(int'(r0) - 1) * MAX_COLS + int'(c0) - 1]);
            end
         end
         ACT_CLEAR: clear_counts();
         default: rep.status = ST_RANGE;
      endcase
      return rep;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatches < MAX_REPORTS) begin
         $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      end
      mismatches++;
   endtask

   // each strobe lasts one cycle and cannot be held off
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("reply with nothing pending", rsp_status, 0);
         end else begin
            oldest_reply = expected_replies.pop_front();
            if (rsp_cell_count !== oldest_reply.count) begin
               report_mismatch("cell_count", rsp_cell_count, oldest_reply.count);
            end
            if (rsp_status !== oldest_reply.status) begin
               report_mismatch("status", rsp_status, oldest_reply.status);
            end
         end
      end
   end

   // start is only lowered for a gap, so a back-to-back transfer never toggles it
   task automatic send_item(input logic [ACTION_W-1:0] act,
                            input coord_type r0, input coord_type r1,
                            input coord_type c0, input coord_type c1);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start         <= 1'b1;
      req_action    <= act;
      req_row_first <= r0;
      req_row_last  <= r1;
      req_col_first <= c0;
      req_col_last  <= c1;
      do @(posedge clock); while (busy !== 1'b0);
      expected_replies.push_back(predict_reply(act, r0, r1, c0, c1));
   endtask

   task automatic wait_until_idle();
      start <= 1'b0;
      while (expected_replies.size() != 0 || busy !== 1'b0) @(posedge clock);
   endtask

   task automatic set_size(input cfg_type rows, input cfg_type cols);
      wait_until_idle();
      csr_wr_en   <= 1'b1;
      csr_index   <= REG_NUM_ROWS;
      csr_wr_data <= rows;
      @(posedge clock);
      csr_index   <= REG_NUM_COLS;
      csr_wr_data <= cols;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      rows_cfg = rows;
      cols_cfg = cols;
   endtask

   function automatic coord_type any_coord();
      return coord_type'($urandom_range(511));
   endfunction

   // mostly boundary or illegal values
   function automatic coord_type odd_coord(input int size);
      case ($urandom_range(3))
         0: return any_coord();
         1: return '0;
         2: return coord_type'(size + 1);
         default: return coord_type'($urandom_range(1, (size > 0) ? size : 1));
      endcase
   endfunction

   // legal range, kept short so one add walks a small rectangle
   function automatic void pick_range(input int size, output coord_type first,
                                      output coord_type last);
      int lo, span;
      lo   = $urandom_range(1, size);
      span = ($urandom_range(49) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
      first = coord_type'(lo);
      if (lo > 1 && $urandom_range(19) == 0) begin
         last = coord_type'($urandom_range(1, lo - 1));
      end else begin
         last = coord_type'((lo + span > size) ? size : lo + span);
      end
   endfunction

   task automatic send_random_item();
      int                  nr, nc, pick;
      logic [ACTION_W-1:0] act;
      coord_type           r0, r1, c0, c1;
      nr   = rows_in_use();
      nc   = cols_in_use();
      pick = (nr == 0 || nc == 0) ? 99 : $urandom_range(99);
      if (pick < 55) begin
         act = ACT_ADD;
         pick_range(nr, r0, r1);
         pick_range(nc, c0, c1);
         hot_row = r0;
         hot_col = c0;
      end else if (pick < 84) begin
         act = ACT_READ;
         if ($urandom_range(1) == 1) begin
            r0 = hot_row;
            c0 = hot_col;
         end else begin
            r0 = coord_type'($urandom_range(1, nr));
            c0 = coord_type'($urandom_range(1, nc));
         end
         r1 = any_coord();
         c1 = any_coord();
      end else begin
         case ($urandom_range(2))
            0: act = ACT_UNUSED;
            1: act = ACT_READ;
            default: act = ACT_ADD;
         endcase
         r0 = odd_coord(nr);
         r1 = odd_coord(nr);
         c0 = odd_coord(nc);
         c1 = odd_coord(nc);
         // a noise add must be rejected, or it could sweep the whole matrix
         if (act == ACT_ADD && in_range(r0, nr) && in_range(r1, nr) &&
             in_range(c0, nc) && in_range(c1, nc)) begin
            c1 = ($urandom_range(1) == 1) ? coord_type'(0) : coord_type'(nc + 1);
         end
      end
      send_item(act, r0, r1, c0, c1);
   endtask

   task automatic random_phase(input cfg_type rows, input cfg_type cols, input int idle_pct,
                               input int n_items, input bit with_clear);
      set_size(rows, cols);
      sender_idle_pct = idle_pct;
      if (with_clear) begin
         send_item(ACT_CLEAR, any_coord(), any_coord(), any_coord(), any_coord());
      end
      repeat (n_items) send_random_item();
   endtask

   task automatic test_reset_state();
      sender_idle_pct = 0;
      send_item(ACT_READ, 9'd1, 9'd0, 9'd1, 9'd0);
      send_item(ACT_ADD, 9'd256, 9'd256, 9'd256, 9'd256);
      // whole matrix, one read-modify-write per cell
      send_item(ACT_ADD, 9'd1, 9'd256, 9'd1, 9'd256);
      send_item(ACT_READ, 9'd256, 9'd511, 9'd256, 9'd511);
      send_item(ACT_READ, 9'd128, 9'd511, 9'd1, 9'd511);
   endtask

   task automatic test_range_checks();
      sender_idle_pct = 0;
      send_item(ACT_ADD, 9'd0, 9'd1, 9'd1, 9'd1);
      send_item(ACT_ADD, 9'd1, 9'd257, 9'd1, 9'd1);
      send_item(ACT_ADD, 9'd1, 9'd1, 9'd511, 9'd1);
      send_item(ACT_ADD, 9'd5, 9'd3, 9'd2, 9'd2);
      // empty range still has its corners checked
      send_item(ACT_ADD, 9'd9, 9'd0, 9'd2, 9'd2);
      send_item(ACT_READ, 9'd0, 9'd1, 9'd1, 9'd1);
      send_item(ACT_READ, 9'd1, 9'd1, 9'd257, 9'd1);
      send_item(ACT_UNUSED, 9'd1, 9'd1, 9'd1, 9'd1);
   endtask

   task automatic test_size_limits();
      set_size(9'd1, 9'd1);
      send_item(ACT_ADD, 9'd1, 9'd1, 9'd1, 9'd1);
      send_item(ACT_ADD, 9'd1, 9'd2, 9'd1, 9'd1);
      send_item(ACT_READ, 9'd1, 9'd0, 9'd1, 9'd0);
      set_size(9'd0, 9'd0);
      send_item(ACT_ADD, 9'd1, 9'd1, 9'd1, 9'd1);
      send_item(ACT_READ, 9'd1, 9'd1, 9'd1, 9'd1);
      // sizes above the physical matrix are clipped to it
      set_size(9'd511, 9'd511);
      send_item(ACT_ADD, 9'd256, 9'd256, 9'd1, 9'd2);
      send_item(ACT_ADD, 9'd257, 9'd257, 9'd1, 9'd1);
      send_item(ACT_READ, 9'd256, 9'd3, 9'd2, 9'd7);
   endtask

   task automatic test_clear();
      set_size(9'd256, 9'd256);
      send_item(ACT_CLEAR, 9'd511, 9'd0, 9'd511, 9'd0);
      send_item(ACT_READ, 9'd256, 9'd0, 9'd256, 9'd0);
      send_item(ACT_READ, 9'd1, 9'd0, 9'd1, 9'd0);
   endtask

   task automatic test_random();
      random_phase(9'd16, 9'd16, 0, 300, 1'b0);
      random_phase(9'd256, 9'd256, 68, 300, 1'b1);
      random_phase(9'd5, 9'd200, 20, 300, 1'b0);
      random_phase(9'd511, 9'd1, 68, 250, 1'b0);
      random_phase(9'd0, 9'd7, 0, 50, 1'b0);
      random_phase(9'd1, 9'd511, 20, 200, 1'b0);
      random_phase(cfg_type'($urandom_range(2, 255)), cfg_type'($urandom_range(2, 255)),
                   68, 250, 1'b1);
   endtask

   initial begin
      clear_counts();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_range_checks();
      test_size_limits();
      test_clear();
      test_random();
      wait_until_idle();
      repeat (300) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS rectangle_increment_count_matrix_core");
      end else begin
         $display("FAIL rectangle_increment_count_matrix_core");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL rectangle_increment_count_matrix_core");
      $finish;
   end

endmodule
